FILE: design/hhpr_pkg.sv
package hhpr_pkg;

	localparam int TEMP_BITS = 10;
	localparam int SUM_BITS  = 32;
	localparam int GAIN_BITS = 16;
	localparam int HYST_BITS = 4;

	// error needs one more bit than a sample, the difference of two errors one more again
	localparam int ERR_BITS  = TEMP_BITS + 1;
	localparam int DIFF_BITS = TEMP_BITS + 2;
	// band thresholds: setpoint +/- band never leaves this range
	localparam int THR_BITS  = TEMP_BITS + 2;
	// control sum of three signed-by-unsigned products
	localparam int CTL_BITS  = GAIN_BITS + SUM_BITS + 3;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = GAIN_BITS;

	localparam int S_TDATA_BITS = ((TEMP_BITS + 7) / 8) * 8;
	localparam int M_TDATA_BITS = 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SETPOINT = 3'd0,
		CFG_USE_PID  = 3'd1,
		CFG_HYST     = 3'd2,
		CFG_GAIN_P   = 3'd3,
		CFG_GAIN_I   = 3'd4,
		CFG_GAIN_D   = 3'd5
	} cfg_idx_t;

	localparam logic [TEMP_BITS-1:0] SETPOINT_RST = '0;
	localparam logic [HYST_BITS-1:0] HYST_RST     = 4'd2;
	localparam logic [GAIN_BITS-1:0] GAIN_P_RST   = 16'd4648;   // 72.63 in Q10.6
	localparam logic [GAIN_BITS-1:0] GAIN_I_RST   = 16'd908;    // 14.19
	localparam logic [GAIN_BITS-1:0] GAIN_D_RST   = 16'd15844;  // 247.56

endpackage

FILE: design/heater_hysteresis_pid_relay.sv
// Heater relay controller. Each temperature sample on the slave stream yields
// exactly one transaction on the master stream carrying the relay state after
// that sample. use_pid = 0 gives on/off control with a dead band of
// +/- hysteresis_band around setpoint; use_pid = 1 turns the relay on when the
// PID sum gain_p*e + gain_i*sum(e) + gain_d*de (gains unsigned Q10.6, integral
// saturating at 32 bits) is positive. A sample is taken into an input register
// and evaluated into the output register, which drives tvalid, so one sample
// per clock is sustained while m_axis_tready does not stall the output. The single
// evaluation step (integral add, widest product 17x32, sign test) sets the
// clock limit. The user must write registers through the cfg port only while no
// sample is in flight; the block itself does not enforce this.
module heater_hysteresis_pid_relay (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [hhpr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [hhpr_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [hhpr_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,  // [9:0] temperature
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [hhpr_pkg::M_TDATA_BITS-1:0]  m_axis_tdata   // [0] heater_on
);
	import hhpr_pkg::*;

	logic signed [TEMP_BITS-1:0] setpoint_q;
	logic                        use_pid_q;
	logic [HYST_BITS-1:0]        hyst_q;
	logic [GAIN_BITS-1:0]        gain_p_q, gain_i_q, gain_d_q;

	logic                        relay_q;
	logic signed [SUM_BITS-1:0]  error_sum_q;
	logic signed [ERR_BITS-1:0]  prev_err_q;

	logic                        v_s1;
	logic signed [TEMP_BITS-1:0] temp_s1;
	logic                        out_valid_q;
	logic                        heater_q;

	logic advance;
	logic in_take;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			use_pid_q  <= 1'b0;
			hyst_q     <= HYST_RST;
			gain_p_q   <= GAIN_P_RST;
			gain_i_q   <= GAIN_I_RST;
			gain_d_q   <= GAIN_D_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SETPOINT: setpoint_q <= cfg_data[TEMP_BITS-1:0];
				CFG_USE_PID:  use_pid_q  <= cfg_data[0];
				CFG_HYST:     hyst_q     <= cfg_data[HYST_BITS-1:0];
				CFG_GAIN_P:   gain_p_q   <= cfg_data[GAIN_BITS-1:0];
				CFG_GAIN_I:   gain_i_q   <= cfg_data[GAIN_BITS-1:0];
				CFG_GAIN_D:   gain_d_q   <= cfg_data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance       = v_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !v_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// on/off evaluation
	logic signed [THR_BITS-1:0] temp_x, sp_x, hyst_x;
	logic                       ge_hi, lt_lo, relay_onoff;

	always_comb begin
		temp_x = THR_BITS'(temp_s1);
		sp_x   = THR_BITS'(setpoint_q);
		hyst_x = signed'(THR_BITS'(hyst_q));
		ge_hi  = temp_x >= sp_x + hyst_x;
		lt_lo  = temp_x < sp_x - hyst_x;
		if (ge_hi)
			relay_onoff = 1'b0;
		else if (!relay_q && lt_lo)
			relay_onoff = 1'b1;
		else
			relay_onoff = relay_q;
	end

	// PID evaluation
	logic signed [ERR_BITS-1:0]             err;
	logic signed [SUM_BITS:0]               sum_wide;
	logic signed [SUM_BITS-1:0]             sum_next;
	logic signed [DIFF_BITS-1:0]            diff;
	logic signed [GAIN_BITS:0]              gp_s, gi_s, gd_s;
	logic signed [GAIN_BITS+ERR_BITS:0]     p_term;
	logic signed [GAIN_BITS+SUM_BITS:0]     i_term;
	logic signed [GAIN_BITS+DIFF_BITS:0]    d_term;
	logic signed [CTL_BITS-1:0]             ctl;

	always_comb begin
		err      = ERR_BITS'(setpoint_q) - ERR_BITS'(temp_s1);
		sum_wide = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(err);
		// top two bits differ: result left the SUM_BITS range
		if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
			sum_next = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
			                              : {1'b0, {(SUM_BITS-1){1'b1}}};
		else
			sum_next = sum_wide[SUM_BITS-1:0];
		diff   = DIFF_BITS'(err) - DIFF_BITS'(prev_err_q);
		gp_s   = signed'({1'b0, gain_p_q});
		gi_s   = signed'({1'b0, gain_i_q});
		gd_s   = signed'({1'b0, gain_d_q});
		p_term = (GAIN_BITS+ERR_BITS+1)'(gp_s) * (GAIN_BITS+ERR_BITS+1)'(err);
		i_term = (GAIN_BITS+SUM_BITS+1)'(gi_s) * (GAIN_BITS+SUM_BITS+1)'(sum_next);
		d_term = (GAIN_BITS+DIFF_BITS+1)'(gd_s) * (GAIN_BITS+DIFF_BITS+1)'(diff);
		ctl    = CTL_BITS'(p_term) + CTL_BITS'(i_term) + CTL_BITS'(d_term);
	end

	logic relay_next;
	assign relay_next = use_pid_q ? (!ctl[CTL_BITS-1] && (ctl != '0)) : relay_onoff;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_axis_tready)
			v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (in_take)
			temp_s1 <= s_axis_tdata[TEMP_BITS-1:0];
	end

	// controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			error_sum_q <= '0;
			prev_err_q  <= '0;
			out_valid_q <= 1'b0;
			heater_q    <= 1'b0;
		end else begin
			if (advance) begin
				relay_q  <= relay_next;
				heater_q <= relay_next;
				if (use_pid_q) begin
					error_sum_q <= sum_next;
					prev_err_q  <= err;
				end
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_BITS-1){1'b0}}, heater_q};

	// checks
	a_onoff_hi_off: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !use_pid_q && ge_hi |=> !relay_q)
		else $error("relay not off above upper threshold");

	a_onoff_pid_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !use_pid_q |=> $stable(error_sum_q) && $stable(prev_err_q))
		else $error("PID state changed in on/off mode");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[0] == relay_q)
		else $error("output disagrees with relay state");

	a_take_loads_stage: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted sample lost");

endmodule
